FILE: rtl/core/ais_pkg.sv
// Shared types, codes and character constants of the ASCII integer field scanner.
`timescale 1ns / 1ps

package ais_pkg;

  // Default result width of the signed and wrapping hex modes
  localparam int unsigned VALUE_BITS_DEF = 64;

  // Configuration port
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam logic        REG_SCAN_MODE = 1'b0;
  localparam logic        REG_UPPERCASE = 1'b1;

  // Scan modes; codes above MODE_HEX_LIMIT run as MODE_UDEC64
  localparam logic [2:0] MODE_UDEC64    = 3'd0;
  localparam logic [2:0] MODE_UDEC32    = 3'd1;
  localparam logic [2:0] MODE_SDEC      = 3'd2;
  localparam logic [2:0] MODE_HEX_WRAP  = 3'd3;
  localparam logic [2:0] MODE_HEX_LIMIT = 3'd4;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_DIGIT = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

  // Characters
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;
  localparam logic [7:0] COUNT_MAX      = 8'd255;
  localparam logic [4:0] HEX_MAX_DIGITS = 5'd16;

  // Field scan state
  typedef struct packed {
    logic [63:0] acc;
    logic        active;
    logic        digit_seen;
    logic [7:0]  count;
    logic        minus;
    logic        lone_zero;
    logic [4:0]  hex_digits;
  } state_t;

  // One result item with its valid flag
  typedef struct packed {
    logic        valid;
    logic [63:0] value;
    status_e     status;
    logic [7:0]  consumed;
  } result_t;

endpackage

FILE: rtl/core/ais_in_if.sv
// Input channel of the scanner: one character item per handshake.
`timescale 1ns / 1ps

interface ais_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_field;

  modport source (output valid, output char_code, output start_field, input ready);
  modport sink   (input valid, input char_code, input start_field, output ready);
endinterface

FILE: rtl/core/ais_out_if.sv
// Output channel of the scanner: one scanned value item per handshake.
`timescale 1ns / 1ps

interface ais_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  status;
  logic [7:0]  consumed;

  modport source (output valid, output value, output status, output consumed, input ready);
  modport sink   (input valid, input value, input status, input consumed, output ready);
endinterface

FILE: rtl/core/ais_step.sv
// Next-state and result logic for one character of a field.
`timescale 1ns / 1ps

module ais_step #(
  parameter int unsigned VALUE_BITS = ais_pkg::VALUE_BITS_DEF
) (
  input  ais_pkg::state_t  state_i,
  input  logic [7:0]       char_i,
  input  logic             start_i,
  input  logic [2:0]       mode_i,
  input  logic             upper_i,
  output ais_pkg::state_t  state_o,
  output ais_pkg::result_t result_o
);

  localparam logic [63:0] VMASK = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam logic [63:0] TOP   = 64'd1 << (VALUE_BITS - 1);

  ais_pkg::state_t s;
  ais_pkg::state_t n;
  ais_pkg::result_t res;
  logic [2:0]  mode;
  logic [63:0] dec_max;
  logic [63:0] hex_mask;
  logic        dec_digit;
  logic [3:0]  dec_val;
  logic [67:0] prod;
  logic        ovf;
  logic        hex_digit;
  logic [7:0]  hex_raw;
  logic [63:0] hex_acc;
  logic [7:0]  count_inc;

  // Start of a field clears the state before the character is scanned
  always_comb begin
    s = state_i;
    if (start_i) begin
      s = '0;
      s.active = 1'b1;
    end
  end

  // Mode decode and datapath terms
  always_comb begin
    mode = (mode_i > ais_pkg::MODE_HEX_LIMIT) ? ais_pkg::MODE_UDEC64 : mode_i;
    if (mode == ais_pkg::MODE_UDEC32) begin
      dec_max = {32'd0, 32'hFFFF_FFFF};
    end else if (mode == ais_pkg::MODE_SDEC) begin
      dec_max = VMASK;
    end else begin
      dec_max = {64{1'b1}};
    end
    hex_mask = (mode == ais_pkg::MODE_HEX_WRAP) ? VMASK : {64{1'b1}};

    dec_digit = (char_i >= ais_pkg::CH_0) && (char_i <= ais_pkg::CH_9);
    dec_val   = 4'(char_i - ais_pkg::CH_0);
    // acc * 10 + digit as 8*acc + 2*acc + digit, with headroom for the compare
    prod = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} + {64'd0, dec_val};
    ovf  = prod > {4'd0, dec_max};

    hex_digit = 1'b1;
    if (dec_digit) begin
      hex_raw = char_i - ais_pkg::CH_0;
    end else if ((char_i >= ais_pkg::CH_LA) && (char_i <= ais_pkg::CH_LF)) begin
      hex_raw = char_i - ais_pkg::CH_LA + ais_pkg::HEX_ALPHA_BASE;
    end else if ((char_i >= ais_pkg::CH_UA) && (char_i <= ais_pkg::CH_UF) && upper_i) begin
      hex_raw = char_i - ais_pkg::CH_UA + ais_pkg::HEX_ALPHA_BASE;
    end else begin
      hex_raw   = 8'd0;
      hex_digit = 1'b0;
    end
    hex_acc = {s.acc[59:0], hex_raw[3:0]} & hex_mask;

    count_inc = (s.count == ais_pkg::COUNT_MAX) ? s.count : s.count + 8'd1;
  end

  // Scan one character
  always_comb begin
    n   = s;
    res = '0;
    if (s.active) begin
      if (mode <= ais_pkg::MODE_SDEC) begin
        if ((mode == ais_pkg::MODE_SDEC) && (s.count == 8'd0) &&
            ((char_i == ais_pkg::CH_PLUS) || (char_i == ais_pkg::CH_MINUS))) begin
          n.minus = (char_i == ais_pkg::CH_MINUS);
          n.count = 8'd1;
        end else if (dec_digit) begin
          if (ovf) begin
            res.valid  = 1'b1;
            res.status = ais_pkg::STATUS_RANGE;
            n.active   = 1'b0;
          end else begin
            n.acc        = prod[63:0];
            n.digit_seen = 1'b1;
            n.count      = count_inc;
          end
        end else begin
          // Field ends here
          res.valid = 1'b1;
          n.active  = 1'b0;
          if (!s.digit_seen) begin
            res.status = ais_pkg::STATUS_NO_DIGIT;
          end else if ((mode == ais_pkg::MODE_SDEC) && ((s.acc & TOP) != 64'd0)) begin
            // Only the most negative value may use the top bit
            if ((s.acc == TOP) && s.minus) begin
              res.value    = s.acc;
              res.consumed = s.count;
            end else begin
              res.status = ais_pkg::STATUS_RANGE;
            end
          end else if ((mode == ais_pkg::MODE_SDEC) && s.minus) begin
            res.value    = (~s.acc + 64'd1) & VMASK;
            res.consumed = s.count;
          end else begin
            res.value    = s.acc;
            res.consumed = s.count;
          end
        end
      end else begin
        if ((mode == ais_pkg::MODE_HEX_LIMIT) && (s.hex_digits >= ais_pkg::HEX_MAX_DIGITS)) begin
          // Sixteen digits taken: any character closes the field
          res.valid    = 1'b1;
          res.value    = s.acc;
          res.consumed = s.count;
          n.active     = 1'b0;
        end else if ((s.count == 8'd1) && s.lone_zero &&
                     ((char_i == ais_pkg::CH_LX) || (char_i == ais_pkg::CH_UX))) begin
          // Skip the 0x prefix
          n.acc        = 64'd0;
          n.digit_seen = 1'b0;
          n.hex_digits = 5'd0;
          n.lone_zero  = 1'b0;
          n.count      = 8'd2;
        end else begin
          n.lone_zero = 1'b0;
          if (hex_digit) begin
            n.acc        = hex_acc;
            n.lone_zero  = (s.count == 8'd0) && (char_i == ais_pkg::CH_0);
            n.digit_seen = 1'b1;
            n.hex_digits = (s.hex_digits >= ais_pkg::HEX_MAX_DIGITS) ?
                           s.hex_digits : s.hex_digits + 5'd1;
            n.count      = count_inc;
          end else begin
            res.valid    = 1'b1;
            res.consumed = s.count;
            n.active     = 1'b0;
            if (!s.digit_seen) begin
              res.status = ais_pkg::STATUS_NO_DIGIT;
            end else begin
              res.value = s.acc;
            end
          end
        end
      end
    end
  end

  assign state_o  = n;
  assign result_o = res;

endmodule

FILE: rtl/core/ascii_integer_field_scanner.sv
// Top level of the ASCII integer field scanner with its register port.
// A result is registered as its closing character leaves the input register.
// Throughput: one character item per cycle unless a waiting result stalls it; the scan
// state loop through ais_step sets it. A result that waits in the output register holds
// every item in the input register, and the input channel once that register is full.
// Reset (rst_ni low, asynchronous) empties both stages, closes any field,
// and sets scan_mode to 0 and uppercase_allowed to 1.
`timescale 1ns / 1ps

module ascii_integer_field_scanner #(
  parameter int unsigned VALUE_BITS = ais_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ais_in_if.sink                             in_i,
  ais_out_if.source                          out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ais_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [ais_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [ais_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  logic            in_valid_q;
  logic [7:0]      in_char_q;
  logic            in_start_q;
  logic            advance;
  logic            in_take;
  logic            cfg_wr;

  logic [2:0]      mode_q;
  logic            upper_q;

  ais_pkg::state_t  state_q;
  ais_pkg::state_t  state_d;
  ais_pkg::state_t  step_state;
  ais_pkg::result_t step_res;

  logic            out_valid_q;
  logic            out_valid_d;
  logic [63:0]     out_value_q;
  logic [1:0]      out_status_q;
  logic [7:0]      out_consumed_q;

  // Handshake control
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_take     = in_i.valid && in_i.ready;
  assign cfg_wr      = psel && penable && pwrite;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q  <= in_i.char_code;
      in_start_q <= in_i.start_field;
    end
  end

  // Character scan
  ais_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .state_i  (state_q),
    .char_i   (in_char_q),
    .start_i  (in_start_q),
    .mode_i   (mode_q),
    .upper_i  (upper_q),
    .state_o  (step_state),
    .result_o (step_res)
  );

  // Advance the scan state; a register write closes the field
  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = step_state;
    end
    if (cfg_wr) begin
      state_d.active = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && step_res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_res.valid) begin
      out_value_q    <= step_res.value;
      out_status_q   <= step_res.status;
      out_consumed_q <= step_res.consumed;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.value    = out_value_q;
  assign out_o.status   = out_status_q;
  assign out_o.consumed = out_consumed_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ais_pkg::MODE_UDEC64;
      upper_q <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2] == ais_pkg::REG_SCAN_MODE) begin
        mode_q <= pwdata[2:0];
      end else begin
        upper_q <= pwdata[0];
      end
    end
  end

  // Register read back
  always_comb begin
    if (paddr[2] == ais_pkg::REG_UPPERCASE) begin
      prdata = {{(ais_pkg::CFG_DATA_BITS - 1){1'b0}}, upper_q};
    end else begin
      prdata = {{(ais_pkg::CFG_DATA_BITS - 3){1'b0}}, mode_q};
    end
  end

  assign pready = 1'b1;

endmodule

FILE: dv/ais_scan_checker.sv
// Scoreboard for the ASCII integer field scanner: tracks fields, predicts and compares scans.
`timescale 1ns / 1ps

module ais_scan_checker #(
  parameter int unsigned VALUE_BITS = ais_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ais_in_if                                 char_mon_i,
  ais_out_if                                scan_mon_i,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ais_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [ais_pkg::CFG_DATA_BITS-1:0] pwdata,
  input  logic                              pready,
  output int unsigned                       fail_count_o,
  output int unsigned                       outstanding_o
);
  import ais_pkg::*;

  typedef struct packed {
    logic [63:0] value;
    status_e     status;
    logic [7:0]  consumed;
  } scan_t;

  scan_t       pending_scans[$];
  int unsigned mismatches = 0;

  // Register copies
  logic [2:0]  cfg_mode;
  logic        cfg_upper;

  // Field state
  logic [63:0] field_acc;
  logic        field_open;
  logic        field_seen;
  logic [7:0]  field_count;
  logic        field_minus;
  logic        field_lone_zero;
  logic [4:0]  field_hex_digits;

  assign fail_count_o = mismatches;

  function automatic bit close_field(input logic [63:0] v, input status_e st,
                                     input logic [7:0] cnt, output scan_t res);
    res.value    = v;
    res.status   = st;
    res.consumed = cnt;
    field_open   = 1'b0;
    return 1'b1;
  endfunction

  function automatic void bump_count();
    if (field_count != COUNT_MAX) field_count++;
  endfunction

  function automatic bit scan_decimal(input logic [2:0] mode, input logic [7:0] c,
                                      output scan_t res);
    int unsigned width;
    logic [63:0] limit;
    logic [63:0] digit;
    logic [63:0] top;
    width = (mode == MODE_UDEC32) ? 32 : ((mode == MODE_SDEC) ? VALUE_BITS : 64);
    limit = {64{1'b1}} >> (64 - width);
    // a sign is taken only as the very first character
    if (mode == MODE_SDEC && field_count == 0 && (c == CH_PLUS || c == CH_MINUS)) begin
      field_minus = (c == CH_MINUS);
      field_count = 8'd1;
      return 1'b0;
    end
    if (c >= CH_0 && c <= CH_9) begin
      digit = 64'(c - CH_0);
      if (field_acc > limit / 64'd10) return close_field('0, STATUS_RANGE, '0, res);
      field_acc = field_acc * 64'd10;
      if (field_acc > limit - digit) return close_field('0, STATUS_RANGE, '0, res);
      field_acc  = field_acc + digit;
      field_seen = 1'b1;
      bump_count();
      return 1'b0;
    end
    if (!field_seen) return close_field('0, STATUS_NO_DIGIT, '0, res);
    if (mode == MODE_SDEC) begin
      top = 64'd1 << (width - 1);
      // only the most negative value may carry the top bit
      if ((field_acc & top) != 0) begin
        if (field_acc == top && field_minus)
          return close_field(field_acc, STATUS_OK, field_count, res);
        return close_field('0, STATUS_RANGE, '0, res);
      end
      if (field_minus) return close_field((-field_acc) & limit, STATUS_OK, field_count, res);
    end
    return close_field(field_acc, STATUS_OK, field_count, res);
  endfunction

  function automatic bit scan_hex(input logic [2:0] mode, input logic [7:0] c,
                                  output scan_t res);
    logic [63:0] digit;
    bit          is_digit;
    if (mode == MODE_HEX_LIMIT && field_hex_digits >= HEX_MAX_DIGITS)
      return close_field(field_acc, STATUS_OK, field_count, res);
    // skip a 0x or 0X prefix
    if (field_count == 8'd1 && field_lone_zero && (c == CH_LX || c == CH_UX)) begin
      field_acc        = '0;
      field_seen       = 1'b0;
      field_hex_digits = '0;
      field_lone_zero  = 1'b0;
      field_count      = 8'd2;
      return 1'b0;
    end
    field_lone_zero = 1'b0;
    is_digit        = 1'b1;
    digit           = '0;
    if (c >= CH_0 && c <= CH_9) digit = 64'(c - CH_0);
    else if (c >= CH_LA && c <= CH_LF) digit = 64'(c - CH_LA + HEX_ALPHA_BASE);
    else if (cfg_upper && c >= CH_UA && c <= CH_UF) digit = 64'(c - CH_UA + HEX_ALPHA_BASE);
    else is_digit = 1'b0;
    if (is_digit) begin
      field_acc = (field_acc << 4) + digit;
      if (mode == MODE_HEX_WRAP) field_acc = field_acc & ({64{1'b1}} >> (64 - VALUE_BITS));
      if (field_count == 0 && c == CH_0) field_lone_zero = 1'b1;
      field_seen = 1'b1;
      if (field_hex_digits < HEX_MAX_DIGITS) field_hex_digits++;
      bump_count();
      return 1'b0;
    end
    if (!field_seen) return close_field('0, STATUS_NO_DIGIT, field_count, res);
    return close_field(field_acc, STATUS_OK, field_count, res);
  endfunction

  // Advance the field by one character; return 1 when it yields a scan
  function automatic bit scan_char(input logic [7:0] c, input logic start, output scan_t res);
    logic [2:0] mode;
    res = '0;
    if (start) begin
      field_acc        = '0;
      field_open       = 1'b1;
      field_seen       = 1'b0;
      field_count      = '0;
      field_minus      = 1'b0;
      field_lone_zero  = 1'b0;
      field_hex_digits = '0;
    end
    if (!field_open) return 1'b0;
    mode = (cfg_mode > MODE_HEX_LIMIT) ? MODE_UDEC64 : cfg_mode;
    if (mode == MODE_UDEC64 || mode == MODE_UDEC32 || mode == MODE_SDEC)
      return scan_decimal(mode, c, res);
    return scan_hex(mode, c, res);
  endfunction

  // Compare scans, predict new ones, follow register writes
  always @(posedge clk_i or negedge rst_ni) begin
    scan_t got;
    scan_t want;
    if (!rst_ni) begin
      pending_scans.delete();
      cfg_mode         = MODE_UDEC64;
      cfg_upper        = 1'b1;
      field_acc        = '0;
      field_open       = 1'b0;
      field_seen       = 1'b0;
      field_count      = '0;
      field_minus      = 1'b0;
      field_lone_zero  = 1'b0;
      field_hex_digits = '0;
      outstanding_o   <= 0;
    end else begin
      if (scan_mon_i.valid && scan_mon_i.ready) begin
        if (pending_scans.size() == 0) begin
          $error("unexpected scan item: value %h status %0d consumed %0d",
                 scan_mon_i.value, scan_mon_i.status, scan_mon_i.consumed);
          mismatches++;
        end else begin
          want = pending_scans.pop_front();
          if (scan_mon_i.value !== want.value) begin
            $error("value: expected %h, actual %h", want.value, scan_mon_i.value);
            mismatches++;
          end
          if (scan_mon_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, scan_mon_i.status);
            mismatches++;
          end
          if (scan_mon_i.consumed !== want.consumed) begin
            $error("consumed: expected %0d, actual %0d", want.consumed, scan_mon_i.consumed);
            mismatches++;
          end
        end
      end
      if (char_mon_i.valid && char_mon_i.ready &&
          scan_char(char_mon_i.char_code, char_mon_i.start_field, got))
        pending_scans.push_back(got);
      // any register write drops an open field
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SCAN_MODE) cfg_mode = pwdata[2:0];
        else cfg_upper = pwdata[0];
        field_open = 1'b0;
      end
      outstanding_o <= pending_scans.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
// Stimulus, clocking and verdict for the ASCII integer field scanner testbench.
`timescale 1ns / 1ps

module tb_top;
  import ais_pkg::*;

  localparam int unsigned VALUE_BITS    = VALUE_BITS_DEF;
  localparam int unsigned RANDOM_CHARS  = 1200;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_SCAN_MODE = {REG_SCAN_MODE, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_UPPERCASE = {REG_UPPERCASE, 2'b00};
  localparam logic [7:0] CH_NUL = 8'h00;

  logic                     clk;
  logic                     rst_n;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic                     pready;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  int unsigned              fail_count;
  int unsigned              outstanding;

  logic [2:0]  cur_mode;
  logic        cur_upper;
  bit          src_calm;
  bit          sink_calm;
  int unsigned chars_sent;
  logic [7:0]  field_text[$];
  string       dec_bounds[8] = '{"18446744073709551615", "18446744073709551616",
                                 "4294967295", "4294967296",
                                 "9223372036854775807", "9223372036854775808",
                                 "99999999999999999999", "00000000000000000000042"};

  ais_in_if  char_ch ();
  ais_out_if scan_ch ();

  ascii_integer_field_scanner #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (char_ch),
    .out_o   (scan_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ais_scan_checker #(.VALUE_BITS(VALUE_BITS)) scan_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .char_mon_i    (char_ch),
    .scan_mon_i    (scan_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold off after a random gap, then offer one character item until taken
  task automatic send_char(input logic [7:0] c, input logic start);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_ch.valid       <= 1'b1;
    char_ch.char_code   <= c;
    char_ch.start_field <= start;
    do @(posedge clk); while (!char_ch.ready);
    chars_sent++;
  endtask

  // Drop valid, wait for every pending scan, then let the pipeline drain
  task automatic settle();
    char_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write both registers while idle; junk in the unused data bits
  task automatic configure(input logic [2:0] mode, input logic upper);
    logic [CFG_DATA_BITS-1:0] word;
    settle();
    word      = $urandom();
    word[2:0] = mode;
    write_reg(ADDR_SCAN_MODE, word);
    word      = $urandom();
    word[0]   = upper;
    write_reg(ADDR_UPPERCASE, word);
    cur_mode  = mode;
    cur_upper = upper;
  endtask

  function automatic bit continues_field(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 1'b1;
    if (cur_mode != MODE_HEX_WRAP && cur_mode != MODE_HEX_LIMIT) return 1'b0;
    return (c >= CH_LA && c <= CH_LF) || (cur_upper && c >= CH_UA && c <= CH_UF);
  endfunction

  task automatic send_text();
    for (int i = 0; i < field_text.size(); i++) send_char(field_text[i], i == 0);
  endtask

  // Build one mostly well-formed field for the current mode with random content
  task automatic compose_field();
    string       bound;
    int unsigned n;
    int unsigned r;
    logic [7:0]  c;
    field_text.delete();
    if (cur_mode == MODE_HEX_WRAP || cur_mode == MODE_HEX_LIMIT) begin
      if ($urandom_range(0, 1) != 0) begin
        field_text.push_back(CH_0);
        field_text.push_back(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX);
      end
      // cluster around the 16-digit limit
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 17) : $urandom_range(0, 20);
      repeat (n) begin
        r = $urandom_range(0, 21);
        if (r < 10) c = CH_0 + 8'(r);
        else if (r < 16) c = CH_LA + 8'(r - 10);
        else c = CH_UA + 8'(r - 16);
        field_text.push_back(c);
      end
    end else begin
      if ((cur_mode == MODE_SDEC) ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 12) == 0))
        field_text.push_back(($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS);
      if ($urandom_range(0, 3) == 0) begin
        // numbers at the edges of the 32 and 64 bit ranges, and long digit runs
        bound = dec_bounds[$urandom_range(0, 7)];
        for (int i = 0; i < bound.len(); i++) field_text.push_back(bound[i]);
        if ($urandom_range(0, 1) != 0)
          field_text[field_text.size() - 1] = CH_0 + 8'($urandom_range(0, 9));
      end else begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 21);
        repeat (n) field_text.push_back(CH_0 + 8'($urandom_range(0, 9)));
      end
    end
    // end on a non-digit, or leave the field for the next start to abandon
    if ($urandom_range(0, 7) != 0) begin
      do c = 8'($urandom_range(0, 255)); while (continues_field(c));
      field_text.push_back(c);
    end
  endtask

  // Output side: random stall before each scan item
  initial begin
    int unsigned stall;
    scan_ch.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        scan_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      scan_ch.ready <= 1'b1;
      do @(posedge clk); while (!scan_ch.valid);
    end
  end

  // Watchdog
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned n;
    rst_n               = 1'b0;
    char_ch.valid       = 1'b0;
    char_ch.char_code   = '0;
    char_ch.start_field = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cur_mode            = MODE_UDEC64;
    cur_upper           = 1'b1;
    src_calm            = 1'b0;
    sink_calm           = 1'b0;
    chars_sent          = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, idle character, NUL end, no digits, abandoned field
    send_char("A", 1'b0);
    send_char("7", 1'b1);
    send_char(CH_NUL, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char("1", 1'b1);
    send_char("2", 1'b1);
    send_char("/", 1'b0);
    // lone sign, then a negative value
    configure(MODE_SDEC, 1'b1);
    send_char(CH_MINUS, 1'b1);
    send_char(CH_NUL, 1'b0);
    send_char(CH_MINUS, 1'b1);
    send_char("5", 1'b0);
    send_char(";", 1'b0);
    // prefix with no digits, and upper-case digits refused
    configure(MODE_HEX_WRAP, 1'b0);
    send_char(CH_0, 1'b1);
    send_char(CH_LX, 1'b0);
    send_char(CH_NUL, 1'b0);
    send_char(CH_0, 1'b1);
    send_char(CH_UX, 1'b0);
    send_char("a", 1'b0);
    send_char("F", 1'b0);
    configure(MODE_HEX_LIMIT, 1'b1);
    send_char(CH_UF, 1'b1);
    send_char("g", 1'b0);
    // reserved mode runs as 64-bit unsigned decimal
    configure(3'd7, 1'b1);
    send_char("9", 1'b1);
    send_char(":", 1'b0);

    // Long zero runs to saturate the consumed count
    src_calm = 1'b1;
    for (int pass = 0; pass < 2; pass++) begin
      configure((pass == 0) ? MODE_UDEC64 : MODE_HEX_WRAP, 1'b1);
      field_text.delete();
      repeat ($urandom_range(256, 300)) field_text.push_back(CH_0);
      field_text.push_back("7");
      field_text.push_back(CH_NUL);
      send_text();
    end

    // Random: mostly well-formed fields, some noise, occasional reconfiguration
    while (chars_sent < RANDOM_CHARS) begin
      src_calm  = ($urandom_range(0, 4) == 0);
      sink_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 11) == 0)
        configure(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          field_text.delete();
          field_text.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) == 0) begin
            send_char(field_text[0], 1'b1);
          end else begin
            send_char(field_text[0], 1'b0);
          end
        end
      end else begin
        compose_field();
        send_text();
      end
    end

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
